// ----- rtl/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants for the sha-256 stream core
// round constants, initial hash values, datapath command and status types and controller states
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       load_byte;  // write byte_val at byte position
        logic [7:0] byte_val;
        logic       out_load;   // not used; the digest word is selected by out_idx
        logic [2:0] out_idx;
        logic       reset_hash; // restore initial chain and counters
        logic       count_byte; // add 8 to bit count
    } t_dp_cmd;

    typedef struct packed {
        logic       busy;       // compression running
        logic       done;       // compression finished this cycle
        logic [5:0] pos;        // next byte slot
        logic [63:0] bits;
    } t_dp_sts;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [255:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] h_init(input logic [2:0] i);
        logic [255:0] v;
        v = H_INIT << {i, 5'd0};
        return v[255:224];
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/sha_datapath.sv -----
// ----------------------------------------------------------------------------
// sha_datapath: block buffer, message schedule and round unit
// one round per cycle over a 16-word rolling schedule window
// ----------------------------------------------------------------------------
module sha_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sha_pkg::t_dp_cmd i_cmd,
    output sha_pkg::t_dp_sts o_sts,
    output logic [31:0]      o_word
);

    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [63:0] r_bits;
    logic [5:0]  r_pos;
    logic [5:0]  r_rnd;
    logic        r_busy;
    logic        r_done;

    logic [31:0] s0, s1, w_new, bs0, bs1, chs, mj, t1, t2, wt;

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    always_comb begin
        s0    = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        wt    = r_w[0];
        bs1   = ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25);
        chs   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1    = r_v[7] + bs1 + chs + sha_pkg::round_k(r_rnd) + wt;
        bs0   = ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22);
        mj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2    = bs0 + mj;
    end

    // block buffer doubles as the schedule window during compression
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end else if (i_cmd.load_byte) begin
            case (r_pos[1:0])
                2'd0:    r_w[r_pos[5:2]][31:24] <= i_cmd.byte_val;
                2'd1:    r_w[r_pos[5:2]][23:16] <= i_cmd.byte_val;
                2'd2:    r_w[r_pos[5:2]][15:8]  <= i_cmd.byte_val;
                default: r_w[r_pos[5:2]][7:0]   <= i_cmd.byte_val;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
            r_pos  <= '0;
            r_bits <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha_pkg::h_init(3'(i));
                r_v[i] <= '0;
            end
        end else begin
            r_done <= 1'b0;
            if (i_cmd.count_byte) r_bits <= r_bits + 64'd8;
            if (i_cmd.reset_hash) begin
                r_bits <= '0;
                r_pos  <= '0;
                for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::h_init(3'(i));
            end
            if (i_cmd.load_byte && !r_busy) begin
                r_pos <= r_pos + 6'd1;
                if (r_pos == 6'd63) begin
                    r_busy <= 1'b1;
                    r_rnd  <= '0;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                end
            end
            if (r_busy) begin
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_rnd  <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_h[0] <= r_h[0] + t1 + t2;
                    r_h[1] <= r_h[1] + r_v[0];
                    r_h[2] <= r_h[2] + r_v[1];
                    r_h[3] <= r_h[3] + r_v[2];
                    r_h[4] <= r_h[4] + r_v[3] + t1;
                    r_h[5] <= r_h[5] + r_v[4];
                    r_h[6] <= r_h[6] + r_v[5];
                    r_h[7] <= r_h[7] + r_v[6];
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_sts.pos  = r_pos;
    assign o_sts.bits = r_bits;
    assign o_word     = r_h[i_cmd.out_idx];

endmodule

// ----- rtl/sha_ctrl.sv -----
// ----------------------------------------------------------------------------
// sha_ctrl: sequencer for byte intake, padding, length and digest output
// feeds the datapath one byte per cycle and waits on compressions
// ----------------------------------------------------------------------------
module sha_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [7:0]       i_in_byte,
    input  logic             i_in_bvalid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [2:0]       o_out_idx,
    input  sha_pkg::t_dp_sts i_sts,
    output sha_pkg::t_dp_cmd o_cmd
);

    sha_pkg::t_state r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       r_ovalid, n_ovalid;
    logic       r_last, n_last;
    logic       take;

    assign take = i_in_valid && o_in_ready;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        n_last   = r_last;
        case (r_state)
            sha_pkg::ST_IDLE: begin
                if (take && i_in_last) n_state = sha_pkg::ST_PAD;
            end
            sha_pkg::ST_PAD: begin
                if (!i_sts.busy) begin
                    n_last = 1'b1;
                    // zeros end once the length field slot is reached
                    if (r_last && i_sts.pos == sha_pkg::LEN_POS) begin
                        n_state = sha_pkg::ST_LEN;
                        n_cnt   = '0;
                        n_last  = 1'b0;
                    end
                end
            end
            sha_pkg::ST_LEN: begin
                if (!i_sts.busy) begin
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) n_state = sha_pkg::ST_COMP;
                end
            end
            sha_pkg::ST_COMP: begin
                if (i_sts.done) begin
                    n_state  = sha_pkg::ST_OUT;
                    n_cnt    = '0;
                    n_ovalid = 1'b1;
                end
            end
            sha_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        n_ovalid = 1'b0;
                        n_state  = sha_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = sha_pkg::ST_IDLE;
        endcase
    end

    // r_last in pad state marks that the 0x80 byte has been written
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_cmd.out_idx = r_cnt;
        case (r_state)
            sha_pkg::ST_IDLE: begin
                o_in_ready      = !i_sts.busy;
                o_cmd.load_byte = take && i_in_bvalid;
                o_cmd.byte_val  = i_in_byte;
                o_cmd.count_byte = take && i_in_bvalid;
            end
            sha_pkg::ST_PAD: begin
                if (!i_sts.busy) begin
                    o_cmd.load_byte = !(r_last && i_sts.pos == sha_pkg::LEN_POS);
                    o_cmd.byte_val  = r_last ? 8'h00 : sha_pkg::PAD_BYTE;
                end
            end
            sha_pkg::ST_LEN: begin
                if (!i_sts.busy) begin
                    o_cmd.load_byte = 1'b1;
                    o_cmd.byte_val  = i_sts.bits[6'(7 - r_cnt)*8 +: 8];
                end
            end
            sha_pkg::ST_OUT: begin
                o_cmd.reset_hash = i_out_ready && r_cnt == 3'd7;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            r_last   <= (r_state == sha_pkg::ST_PAD) ? n_last : 1'b0;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_idx   = r_cnt;

endmodule

// ----- rtl/sha256_hash_stream_core.sv -----
// ----------------------------------------------------------------------------
// sha256_hash_stream_core: streaming sha-256 hash engine
// ----------------------------------------------------------------------------
// input transaction: one message byte with a byte-valid flag (tuser) and an
// end-of-message flag (tlast). a transaction with tuser low only closes the
// message. output: eight 32-bit digest words, word 0 first, tlast on word 7.
// each accepted byte goes into the block buffer; every 64th byte starts a
// compression during which s_axis_tready is low. the round unit (one sha-256
// round per cycle) sets how long a compression holds off new input.
// after the final transaction, padding and length bytes go in one per cycle
// while no compression runs; one or two compressions run, then the digest
// words leave one per accepted output transaction; no new input is taken
// until all eight leave. a stalled receiver simply holds the current word.
// reset restores the initial hash values and clears counters; the block
// buffer needs no clearing, since each block is fully written before use.
// ----------------------------------------------------------------------------
module sha256_hash_stream_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // data_byte
    input  logic        s_axis_tuser,  // byte_valid
    input  logic        s_axis_tlast,  // message_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // digest_word[31:0], word_number[34:32], zero
    output logic        m_axis_tlast   // digest_last
);

    sha_pkg::t_dp_cmd cmd;
    sha_pkg::t_dp_sts sts;
    logic [31:0] word;
    logic [2:0]  idx;

    sha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_byte   (s_axis_tdata),
        .i_in_bvalid (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_idx   (idx),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sha_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_word  (word)
    );

    assign m_axis_tdata = {5'd0, idx, word};
    assign m_axis_tlast = (idx == 3'd7);

endmodule

// ----- rtl/sha_checker.sv -----
// ----------------------------------------------------------------------------
// sha_checker: port-level checks for the sha-256 stream core
// ----------------------------------------------------------------------------
module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // no input while digest is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
        else $error("tlast mismatch");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
        else $error("word order broken");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output changed");

endmodule

bind sha256_hash_stream_core sha_checker u_sha_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
